@@ rtl/core/counting_multiset_table_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the counting multiset table
// ---------------------------------------------------------------------------
`ifndef COUNTING_MULTISET_TABLE_DEFINES_SVH
`define COUNTING_MULTISET_TABLE_DEFINES_SVH

// same-cycle implication
`define CMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cms_pkg.sv @@
// ---------------------------------------------------------------------------
// cms_pkg
// Request, status and state codes shared by the counting multiset table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cms_pkg;

  typedef enum logic [3:0] {
    REQ_INSERT    = 4'd0,
    REQ_ERASE_ONE = 4'd1,
    REQ_ERASE_ALL = 4'd2,
    REQ_COUNT_EQ  = 4'd3,
    REQ_COUNT_LT  = 4'd4,
    REQ_COUNT_GT  = 4'd5,
    REQ_GET       = 4'd6,
    REQ_SMALLEST  = 4'd7,
    REQ_SECOND    = 4'd8,
    REQ_LEAST     = 4'd9,
    REQ_REPLACE   = 4'd10
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOTFOUND = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_INVALID  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  // control broadcast to every cell of the ring
  typedef struct packed {
    logic rotate;
    logic wr_en;
    logic rm_en;
  } cell_ctl_t;

  localparam logic [21:0] OUT_MAX22 = 22'h3FFFFF;
  localparam logic [6:0]  OUT_MAX7  = 7'h7F;

endpackage

@@ rtl/core/cms_cell.sv @@
// ---------------------------------------------------------------------------
// cms_cell
// One table entry of the ring: rotates, takes a write, or shifts down.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cms_cell #(
  parameter int IDX         = 0,
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  cms_pkg::cell_ctl_t          ctl_i,
  input  logic [$clog2(CAPACITY)-1:0] wr_idx_i,
  input  logic [KEY_WIDTH-1:0]        wr_key_i,
  input  logic [COUNT_WIDTH-1:0]      wr_cnt_i,
  input  logic [$clog2(CAPACITY)-1:0] rm_idx_i,
  input  logic [KEY_WIDTH-1:0]        nb_key_i,
  input  logic [COUNT_WIDTH-1:0]      nb_cnt_i,
  output logic [KEY_WIDTH-1:0]        key_o,
  output logic [COUNT_WIDTH-1:0]      cnt_o
);
  import cms_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   wr_hit;

  // post-write value, also what the lower neighbor sees
  assign wr_hit = ctl_i.wr_en && (wr_idx_i == MY_IDX);
  assign key_o  = wr_hit ? wr_key_i : key_q;
  assign cnt_o  = wr_hit ? wr_cnt_i : cnt_q;

  always_comb begin
    if (ctl_i.rotate || (ctl_i.rm_en && (MY_IDX >= rm_idx_i))) begin
      key_d = nb_key_i;
      cnt_d = nb_cnt_i;
    end else begin
      key_d = key_o;
      cnt_d = cnt_o;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
  end

endmodule

@@ rtl/core/cms_scan.sv @@
// ---------------------------------------------------------------------------
// cms_scan
// Head-of-ring accumulator: sees one entry per cycle and gathers searches,
// sums and minimums for the pending request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cms_scan #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        en_i,
  input  logic [$clog2(CAPACITY)-1:0] idx_i,
  input  logic [KEY_WIDTH-1:0]        e_key_i,
  input  logic [COUNT_WIDTH-1:0]      e_cnt_i,
  input  logic [3:0]                  req_i,
  input  logic [KEY_WIDTH-1:0]        key_i,
  input  logic [KEY_WIDTH-1:0]        new_key_i,
  input  logic [5:0]                  pos_i,
  output logic                        fk_hit_o,
  output logic [$clog2(CAPACITY)-1:0] fk_idx_o,
  output logic [COUNT_WIDTH-1:0]      fk_cnt_o,
  output logic                        fn_hit_o,
  output logic [$clog2(CAPACITY)-1:0] fn_idx_o,
  output logic [COUNT_WIDTH-1:0]      fn_cnt_o,
  output logic [COUNT_WIDTH+$clog2(CAPACITY+1)-1:0] sum_o,
  output logic [KEY_WIDTH-1:0]        pos_key_o,
  output logic [COUNT_WIDTH-1:0]      pos_cnt_o,
  output logic [KEY_WIDTH-1:0]        lo_key_o,
  output logic [COUNT_WIDTH-1:0]      lo_cnt_o,
  output logic                        hi_have_o,
  output logic [KEY_WIDTH-1:0]        hi_key_o,
  output logic [COUNT_WIDTH-1:0]      hi_cnt_o,
  output logic [KEY_WIDTH-1:0]        mc_key_o,
  output logic [COUNT_WIDTH-1:0]      mc_cnt_o,
  output logic                        mc_tie_o
);
  import cms_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int SW = COUNT_WIDTH + $clog2(CAPACITY + 1);
  localparam int PW = (IW > 6) ? IW : 6;

  logic lo_have_q, mc_have_q;
  logic sel;

  always_comb begin
    unique case (req_i)
      REQ_COUNT_EQ: sel = (e_key_i == key_i);
      REQ_COUNT_LT: sel = (e_key_i < key_i);
      REQ_COUNT_GT: sel = (e_key_i > key_i);
      default:      sel = 1'b0;
    endcase
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fk_hit_o  <= 1'b0;
      fn_hit_o  <= 1'b0;
      lo_have_q <= 1'b0;
      hi_have_o <= 1'b0;
      mc_have_q <= 1'b0;
      mc_tie_o  <= 1'b0;
    end else if (clear_i) begin
      fk_hit_o  <= 1'b0;
      fn_hit_o  <= 1'b0;
      lo_have_q <= 1'b0;
      hi_have_o <= 1'b0;
      mc_have_q <= 1'b0;
      mc_tie_o  <= 1'b0;
    end else if (en_i) begin
      if (e_key_i == key_i)     fk_hit_o <= 1'b1;
      if (e_key_i == new_key_i) fn_hit_o <= 1'b1;
      lo_have_q <= 1'b1;
      if (lo_have_q) hi_have_o <= 1'b1;
      mc_have_q <= 1'b1;
      if (!mc_have_q || (e_cnt_i < mc_cnt_o)) begin
        mc_tie_o <= 1'b0;
      end else if (e_cnt_i == mc_cnt_o) begin
        mc_tie_o <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      sum_o <= '0;
    end else if (en_i) begin
      if (sel) sum_o <= sum_o + SW'(e_cnt_i);
      if ((e_key_i == key_i) && !fk_hit_o) begin
        fk_idx_o <= idx_i;
        fk_cnt_o <= e_cnt_i;
      end
      if ((e_key_i == new_key_i) && !fn_hit_o) begin
        fn_idx_o <= idx_i;
        fn_cnt_o <= e_cnt_i;
      end
      if (PW'(idx_i) == PW'(pos_i)) begin
        pos_key_o <= e_key_i;
        pos_cnt_o <= e_cnt_i;
      end
      if (!lo_have_q) begin
        lo_key_o <= e_key_i;
        lo_cnt_o <= e_cnt_i;
      end else if (e_key_i < lo_key_o) begin
        hi_key_o <= lo_key_o;
        hi_cnt_o <= lo_cnt_o;
        lo_key_o <= e_key_i;
        lo_cnt_o <= e_cnt_i;
      end else if (!hi_have_o || (e_key_i < hi_key_o)) begin
        hi_key_o <= e_key_i;
        hi_cnt_o <= e_cnt_i;
      end
      if (!mc_have_q || (e_cnt_i < mc_cnt_o)) begin
        mc_key_o <= e_key_i;
        mc_cnt_o <= e_cnt_i;
      end
    end
  end

endmodule

@@ rtl/core/counting_multiset_table.sv @@
// ---------------------------------------------------------------------------
// counting_multiset_table
// Table of distinct keys in insertion order with occurrence counts.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The entries sit in
// a ring of CAPACITY cells that rotates once past a scan unit, one entry per
// cycle; then the apply state updates all cells at once. The result shows on
// done_o for exactly one cycle, registered from the apply state; the receiver
// cannot stall it. busy drops in that same cycle, and no new request is taken
// until then.
`timescale 1ns / 1ps

module counting_multiset_table #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic [31:0] new_key_i,
  input  logic [5:0]  position_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [21:0] result_count_o,
  output logic [31:0] result_key_o,
  output logic [6:0]  distinct_entries_o,
  output logic [21:0] total_items_o
);
  import cms_pkg::*;

  localparam int IW  = $clog2(CAPACITY);
  localparam int FW  = $clog2(CAPACITY + 1);
  localparam int SW  = COUNT_WIDTH + FW;
  localparam int TW  = (SW > 22) ? SW : 22;
  localparam int DW  = (FW > 7) ? FW : 7;
  localparam int PW2 = (FW > 6) ? FW : 6;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  state_e state_q, state_d;
  logic [IW-1:0] i_q;
  logic [FW-1:0] fill_q, fill_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          accept;

  logic [3:0]           req_q;
  logic [KEY_WIDTH-1:0] k_q, nk_q;
  logic [5:0]           pos_q;

  cell_ctl_t            ctl;
  logic [IW-1:0]        wr_idx, rm_idx;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [COUNT_WIDTH-1:0] wr_cnt;

  logic [KEY_WIDTH-1:0]   ring_key [CAPACITY];
  logic [COUNT_WIDTH-1:0] ring_cnt [CAPACITY];

  logic                   fk_hit, fn_hit, hi_have, mc_tie;
  logic [IW-1:0]          fk_idx, fn_idx;
  logic [COUNT_WIDTH-1:0] fk_cnt, fn_cnt, pos_cnt, lo_cnt, hi_cnt, mc_cnt;
  logic [KEY_WIDTH-1:0]   pos_key, lo_key, hi_key, mc_key;
  logic [SW-1:0]          scan_sum;

  status_e                status;
  logic [SW-1:0]          rcount;
  logic [KEY_WIDTH-1:0]   rkey;
  logic [COUNT_WIDTH:0]   merged;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int NB = (g + 1) % CAPACITY;
      cms_cell #(
        .IDX(g), .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
      ) u_cell (
        .clk_i    (clk_i),
        .ctl_i    (ctl),
        .wr_idx_i (wr_idx),
        .wr_key_i (wr_key),
        .wr_cnt_i (wr_cnt),
        .rm_idx_i (rm_idx),
        .nb_key_i (ring_key[NB]),
        .nb_cnt_i (ring_cnt[NB]),
        .key_o    (ring_key[g]),
        .cnt_o    (ring_cnt[g])
      );
    end
  endgenerate

  cms_scan #(
    .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (accept),
    .en_i      ((state_q == ST_SCAN) && (FW'(i_q) < fill_q)),
    .idx_i     (i_q),
    .e_key_i   (ring_key[0]),
    .e_cnt_i   (ring_cnt[0]),
    .req_i     (req_q),
    .key_i     (k_q),
    .new_key_i (nk_q),
    .pos_i     (pos_q),
    .fk_hit_o  (fk_hit),
    .fk_idx_o  (fk_idx),
    .fk_cnt_o  (fk_cnt),
    .fn_hit_o  (fn_hit),
    .fn_idx_o  (fn_idx),
    .fn_cnt_o  (fn_cnt),
    .sum_o     (scan_sum),
    .pos_key_o (pos_key),
    .pos_cnt_o (pos_cnt),
    .lo_key_o  (lo_key),
    .lo_cnt_o  (lo_cnt),
    .hi_have_o (hi_have),
    .hi_key_o  (hi_key),
    .hi_cnt_o  (hi_cnt),
    .mc_key_o  (mc_key),
    .mc_cnt_o  (mc_cnt),
    .mc_tie_o  (mc_tie)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == ST_APPLY);
      if (accept) i_q <= '0;
      else if (state_q == ST_SCAN) i_q <= i_q + 1'b1;
      if (state_q == ST_APPLY) begin
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      k_q    <= KEY_WIDTH'(key_i);
      nk_q   <= KEY_WIDTH'(new_key_i);
      pos_q  <= position_i;
    end
    if (state_q == ST_APPLY) begin
      status_o       <= status;
      result_key_o   <= 32'(rkey);
      result_count_o <= (TW'(rcount) > TW'(OUT_MAX22)) ? OUT_MAX22 : 22'(rcount);
      total_items_o  <= (TW'(sum_d) > TW'(OUT_MAX22)) ? OUT_MAX22 : 22'(sum_d);
      distinct_entries_o <= (DW'(fill_d) > DW'(OUT_MAX7)) ? OUT_MAX7 : 7'(fill_d);
    end
  end

  always_comb begin
    state_d = state_q;
    ctl     = '0;
    wr_idx  = '0;
    wr_key  = k_q;
    wr_cnt  = '0;
    rm_idx  = '0;
    fill_d  = fill_q;
    sum_d   = sum_q;
    status  = STATUS_OK;
    rcount  = '0;
    rkey    = '0;
    merged  = {1'b0, fn_cnt} + {1'b0, fk_cnt};
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        ctl.rotate = 1'b1;
        if (i_q == IW'(CAPACITY - 1)) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        state_d = ST_IDLE;
        unique case (req_q)
          REQ_INSERT: begin
            if (fk_hit) begin
              if (fk_cnt == CMAX) begin
                status = STATUS_FULL;
              end else begin
                ctl.wr_en = 1'b1;
                wr_idx    = fk_idx;
                wr_cnt    = fk_cnt + 1'b1;
                rcount    = SW'(wr_cnt);
                sum_d     = sum_q + 1'b1;
              end
            end else if (fill_q == FW'(CAPACITY)) begin
              status = STATUS_FULL;
            end else begin
              ctl.wr_en = 1'b1;
              wr_idx    = IW'(fill_q);
              wr_cnt    = COUNT_WIDTH'(1);
              rcount    = SW'(1);
              fill_d    = fill_q + 1'b1;
              sum_d     = sum_q + 1'b1;
            end
          end
          REQ_ERASE_ONE: begin
            if (!fk_hit) begin
              status = STATUS_NOTFOUND;
            end else begin
              rcount = SW'(1);
              sum_d  = sum_q - 1'b1;
              if (fk_cnt <= COUNT_WIDTH'(1)) begin
                ctl.rm_en = 1'b1;
                rm_idx    = fk_idx;
                fill_d    = fill_q - 1'b1;
              end else begin
                ctl.wr_en = 1'b1;
                wr_idx    = fk_idx;
                wr_cnt    = fk_cnt - 1'b1;
              end
            end
          end
          REQ_ERASE_ALL: begin
            if (!fk_hit) begin
              status = STATUS_NOTFOUND;
            end else begin
              rcount    = SW'(fk_cnt);
              ctl.rm_en = 1'b1;
              rm_idx    = fk_idx;
              fill_d    = fill_q - 1'b1;
              sum_d     = sum_q - SW'(fk_cnt);
            end
          end
          REQ_COUNT_EQ, REQ_COUNT_LT, REQ_COUNT_GT: begin
            rcount = scan_sum;
          end
          REQ_GET: begin
            if (PW2'(pos_q) < PW2'(fill_q)) begin
              rkey   = pos_key;
              rcount = SW'(pos_cnt);
            end else begin
              status = STATUS_NOTFOUND;
            end
          end
          REQ_SMALLEST: begin
            if (fill_q == '0) begin
              status = STATUS_NOTFOUND;
            end else begin
              rkey   = lo_key;
              rcount = SW'(lo_cnt);
            end
          end
          REQ_SECOND: begin
            if (!hi_have) begin
              status = STATUS_NOTFOUND;
            end else begin
              rkey   = hi_key;
              rcount = SW'(hi_cnt);
            end
          end
          REQ_LEAST: begin
            if ((fill_q == '0) || mc_tie) begin
              status = STATUS_NOTFOUND;
            end else begin
              rkey   = mc_key;
              rcount = SW'(mc_cnt);
            end
          end
          REQ_REPLACE: begin
            if (k_q == nk_q) begin
              if (fk_hit) rcount = SW'(fk_cnt);
            end else if (!fk_hit) begin
              status = STATUS_NOTFOUND;
            end else if (!fn_hit) begin
              ctl.wr_en = 1'b1;
              wr_idx    = fk_idx;
              wr_key    = nk_q;
              wr_cnt    = fk_cnt;
              rkey      = nk_q;
              rcount    = SW'(fk_cnt);
            end else if (merged[COUNT_WIDTH]) begin
              status = STATUS_FULL;
            end else begin
              // merge into the new key's entry, then close the old one's gap
              ctl.wr_en = 1'b1;
              wr_idx    = fn_idx;
              wr_key    = nk_q;
              wr_cnt    = merged[COUNT_WIDTH-1:0];
              ctl.rm_en = 1'b1;
              rm_idx    = fk_idx;
              fill_d    = fill_q - 1'b1;
              rkey      = nk_q;
              rcount    = SW'(merged[COUNT_WIDTH-1:0]);
            end
          end
          default: begin
            status = STATUS_INVALID;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/cms_checker.sv @@
// ---------------------------------------------------------------------------
// cms_checker
// Port-level assertions for the counting multiset table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "counting_multiset_table_defines.svh"

module cms_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [21:0] result_count_o,
  input logic [31:0] result_key_o,
  input logic [6:0]  distinct_entries_o
);
  import cms_pkg::*;

  `CMS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "no busy after accept")
  `CMS_ASSERT_NOW(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy), "word without request")
  `CMS_ASSERT_NOW(a_key_zero, clk_i, rst_ni, done_o && (status_o != STATUS_OK), result_key_o == '0, "key on failure")
  `CMS_ASSERT_NOW(a_fill_cap, clk_i, rst_ni, done_o, 32'(distinct_entries_o) <= CAPACITY, "fill over capacity")
  `CMS_ASSERT_NOW(a_invalid_cnt, clk_i, rst_ni, done_o && (status_o == STATUS_INVALID), result_count_o == '0, "count on invalid")

endmodule

bind counting_multiset_table cms_checker #(.CAPACITY(CAPACITY)) u_cms_checker (.*);

@@ bench/counting_multiset_table_test.sv @@
// ---------------------------------------------------------------------------
// counting_multiset_table_test
// Self-checking bench: a queue-fed command driver, an in-bench model of the
// keyed count table, and a monitor that checks every done_o word field by
// field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module counting_multiset_table_test;
  import cms_pkg::*;

  localparam int SLOTS     = 64;
  localparam int CNT_MAX   = 65535;
  localparam int DONE_WAIT = SLOTS + 10;

  typedef struct {
    logic [3:0]  req;
    logic [31:0] key;
    logic [31:0] new_key;
    logic [5:0]  pos;
    int          idle_pct;
    bit          sync;
  } cmd_t;

  typedef struct {
    status_e     status;
    logic [21:0] count;
    logic [31:0] key;
    logic [6:0]  distinct;
    logic [21:0] total;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  req_type_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] new_key_i = '0;
  logic [5:0]  position_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [21:0] result_count_o;
  logic [31:0] result_key_o;
  logic [6:0]  distinct_entries_o;
  logic [21:0] total_items_o;

  counting_multiset_table dut (.*);

  always #2 clk_i = ~clk_i;

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  cmd_t    in_flight;
  int      errors = 0;

  // table model
  logic [31:0] tbl_key[SLOTS];
  int unsigned tbl_cnt[SLOTS];
  int unsigned tbl_fill = 0;

  function automatic int unsigned find_slot(logic [31:0] k);
    for (int i = 0; i < tbl_fill; i++)
      if (tbl_key[i] == k) return i;
    return tbl_fill;
  endfunction

  function automatic void drop_slot(int unsigned idx);
    for (int i = idx; i + 1 < tbl_fill; i++) begin
      tbl_key[i] = tbl_key[i + 1];
      tbl_cnt[i] = tbl_cnt[i + 1];
    end
    tbl_fill--;
  endfunction

  function automatic answer_t apply_request(cmd_t c);
    answer_t     a;
    int unsigned idx, io, inew, lo, hi, ties, n;
    longint unsigned acc;
    a = '{STATUS_OK, '0, '0, '0, '0};
    n = tbl_fill;
    acc = 0;
    case (c.req)
      REQ_INSERT: begin
        idx = find_slot(c.key);
        if (idx < n) begin
          if (tbl_cnt[idx] >= CNT_MAX) a.status = STATUS_FULL;
          else begin
            tbl_cnt[idx]++;
            a.count = tbl_cnt[idx];
          end
        end else if (n >= SLOTS) a.status = STATUS_FULL;
        else begin
          tbl_key[n] = c.key;
          tbl_cnt[n] = 1;
          tbl_fill++;
          a.count = 1;
        end
      end
      REQ_ERASE_ONE: begin
        idx = find_slot(c.key);
        if (idx >= n) a.status = STATUS_NOTFOUND;
        else begin
          a.count = 1;
          if (tbl_cnt[idx] <= 1) drop_slot(idx);
          else tbl_cnt[idx]--;
        end
      end
      REQ_ERASE_ALL: begin
        idx = find_slot(c.key);
        if (idx >= n) a.status = STATUS_NOTFOUND;
        else begin
          a.count = tbl_cnt[idx];
          drop_slot(idx);
        end
      end
      REQ_COUNT_EQ, REQ_COUNT_LT, REQ_COUNT_GT: begin
        for (int i = 0; i < n; i++)
          if ((c.req == REQ_COUNT_EQ && tbl_key[i] == c.key) ||
              (c.req == REQ_COUNT_LT && tbl_key[i] < c.key) ||
              (c.req == REQ_COUNT_GT && tbl_key[i] > c.key))
            acc += tbl_cnt[i];
        a.count = (acc > OUT_MAX22) ? OUT_MAX22 : acc[21:0];
      end
      REQ_GET: begin
        if (c.pos < n) begin
          a.key = tbl_key[c.pos];
          a.count = tbl_cnt[c.pos];
        end else a.status = STATUS_NOTFOUND;
      end
      REQ_SMALLEST: begin
        if (n == 0) a.status = STATUS_NOTFOUND;
        else begin
          idx = 0;
          for (int i = 1; i < n; i++)
            if (tbl_key[i] < tbl_key[idx]) idx = i;
          a.key = tbl_key[idx];
          a.count = tbl_cnt[idx];
        end
      end
      REQ_SECOND: begin
        if (n < 2) a.status = STATUS_NOTFOUND;
        else begin
          lo = 0;
          hi = 1;
          if (tbl_key[1] < tbl_key[0]) begin
            lo = 1;
            hi = 0;
          end
          for (int i = 2; i < n; i++) begin
            if (tbl_key[i] < tbl_key[lo]) begin
              hi = lo;
              lo = i;
            end else if (tbl_key[i] < tbl_key[hi]) hi = i;
          end
          a.key = tbl_key[hi];
          a.count = tbl_cnt[hi];
        end
      end
      REQ_LEAST: begin
        if (n == 0) a.status = STATUS_NOTFOUND;
        else begin
          ties = 1;
          idx = 0;
          for (int i = 1; i < n; i++) begin
            if (tbl_cnt[i] < tbl_cnt[idx]) begin
              idx = i;
              ties = 1;
            end else if (tbl_cnt[i] == tbl_cnt[idx]) ties++;
          end
          if (ties == 1) begin
            a.key = tbl_key[idx];
            a.count = tbl_cnt[idx];
          end else a.status = STATUS_NOTFOUND;
        end
      end
      REQ_REPLACE: begin
        if (c.key == c.new_key) begin
          idx = find_slot(c.key);
          if (idx < n) a.count = tbl_cnt[idx];
        end else begin
          io = find_slot(c.key);
          inew = find_slot(c.new_key);
          if (io >= n) a.status = STATUS_NOTFOUND;
          else if (inew >= n) begin
            tbl_key[io] = c.new_key;
            a.key = c.new_key;
            a.count = tbl_cnt[io];
          end else if (tbl_cnt[inew] + tbl_cnt[io] > CNT_MAX) a.status = STATUS_FULL;
          else begin
            tbl_cnt[inew] += tbl_cnt[io];
            a.key = c.new_key;
            a.count = tbl_cnt[inew];
            drop_slot(io);
          end
        end
      end
      default: a.status = STATUS_INVALID;
    endcase
    acc = 0;
    for (int i = 0; i < tbl_fill; i++) acc += tbl_cnt[i];
    a.total = (acc > OUT_MAX22) ? OUT_MAX22 : acc[21:0];
    a.distinct = tbl_fill[6:0];
    return a;
  endfunction

  // driver: holds start until the word is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_answers.push_back(apply_request(in_flight));
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 &&
            !(pending_cmds[0].sync && (expected_answers.size() > 0 || start)) &&
            $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
          in_flight = pending_cmds.pop_front();
          start <= 1'b1;
          req_type_i <= in_flight.req;
          key_i <= in_flight.key;
          new_key_i <= in_flight.new_key;
          position_i <= in_flight.pos;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // monitor
  always @(posedge clk_i) begin
    answer_t w;
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        w = expected_answers.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (result_count_o !== w.count) report_mismatch("count", result_count_o, w.count);
        if (result_key_o !== w.key) report_mismatch("key", result_key_o, w.key);
        if (distinct_entries_o !== w.distinct)
          report_mismatch("distinct", distinct_entries_o, w.distinct);
        if (total_items_o !== w.total) report_mismatch("total", total_items_o, w.total);
      end
    end
  end

  function automatic logic [31:0] pool_key(int unsigned n);
    return n * 32'h9E3779B1;
  endfunction

  function automatic cmd_t mk(logic [3:0] r, logic [31:0] k, logic [31:0] nk,
                              logic [5:0] p);
    cmd_t c;
    c = '{r, k, nk, p, 0, 1'b0};
    return c;
  endfunction

  initial begin
    cmd_t        c;
    int          pool, roll;
    int          idle_mode[4] = '{0, 74, 0, 9};
    logic [31:0] k_max = 32'hFFFF_FFFF;

    // directed: empty table, extremes, merge and rename, invalid codes
    pending_cmds.push_back(mk(REQ_SMALLEST, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_SECOND, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_LEAST, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_ERASE_ONE, 5, 0, 0));
    pending_cmds.push_back(mk(REQ_ERASE_ALL, 5, 0, 0));
    pending_cmds.push_back(mk(REQ_GET, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_COUNT_EQ, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_REPLACE, 1, 2, 0));
    pending_cmds.push_back(mk(REQ_REPLACE, 7, 7, 0));
    pending_cmds.push_back(mk(REQ_INSERT, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_INSERT, k_max, 0, 0));
    pending_cmds.push_back(mk(REQ_INSERT, k_max, 0, 0));
    pending_cmds.push_back(mk(REQ_LEAST, 0, 0, 0));  // head holds the unique minimum
    pending_cmds.push_back(mk(REQ_SMALLEST, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_SECOND, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_COUNT_LT, k_max, 0, 0));
    pending_cmds.push_back(mk(REQ_COUNT_GT, 0, 0, 0));
    pending_cmds.push_back(mk(REQ_GET, 0, 0, 1));
    pending_cmds.push_back(mk(REQ_GET, 0, 0, 6'h3F));
    pending_cmds.push_back(mk(REQ_REPLACE, 0, k_max, 0));        // merge
    pending_cmds.push_back(mk(REQ_REPLACE, k_max, 32'h1234, 0)); // rename
    pending_cmds.push_back(mk(REQ_REPLACE, 32'h1234, 32'h1234, 0));
    pending_cmds.push_back(mk(REQ_ERASE_ONE, 32'h1234, 0, 0));
    pending_cmds.push_back(mk(REQ_ERASE_ALL, 32'h1234, 0, 0));
    pending_cmds.push_back(mk(4'd11, 0, 0, 0));
    pending_cmds.push_back(mk(4'd15, k_max, k_max, 6'h3F));

    // random phases; a wide key pool fills the table to capacity
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 232; i++) begin
        if (i % 40 == 0) begin
          roll = $urandom_range(0, 2);
          pool = (roll == 0) ? 4 : (roll == 1) ? 16 : 90;
        end
        c.idle_pct = (i % 60 < 10) ? 0 : idle_mode[ph];
        c.sync = (i == 0);
        c.key = ($urandom_range(0, 9) == 0) ? $urandom : pool_key($urandom_range(0, pool - 1));
        c.new_key = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : pool_key($urandom_range(0, pool - 1));
        c.pos = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 7);
        roll = $urandom_range(0, 99);
        if (roll < 35) c.req = REQ_INSERT;
        else if (roll < 45) c.req = REQ_ERASE_ONE;
        else if (roll < 50) c.req = REQ_ERASE_ALL;
        else if (roll < 56) c.req = REQ_COUNT_EQ;
        else if (roll < 61) c.req = REQ_COUNT_LT;
        else if (roll < 66) c.req = REQ_COUNT_GT;
        else if (roll < 74) c.req = REQ_GET;
        else if (roll < 79) c.req = REQ_SMALLEST;
        else if (roll < 84) c.req = REQ_SECOND;
        else if (roll < 90) c.req = REQ_LEAST;
        else if (roll < 97) c.req = REQ_REPLACE;
        else c.req = $urandom_range(11, 15);
        pending_cmds.push_back(c);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && !start && expected_answers.size() == 0);
    repeat (DONE_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cms_pkg.sv
rtl/core/cms_cell.sv
rtl/core/cms_scan.sv
rtl/core/counting_multiset_table.sv
rtl/core/cms_checker.sv
bench/counting_multiset_table_test.sv
